// ===== sv/pixel_histogram_bar_scaler_assert.svh =====
// assertion macros shared by the histogram engine
`ifndef PIXEL_HISTOGRAM_BAR_SCALER_ASSERT_SVH
`define PIXEL_HISTOGRAM_BAR_SCALER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PHBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("histogram check failed");

// next-cycle implication, checked outside reset
`define PHBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("histogram sequencing check failed");

`endif

// ===== sv/phbs_pkg.sv =====
package phbs_pkg;

  // fixed field widths
  localparam int unsigned VAL_W  = 8;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned STAT_W = 2;

  // sizing
  localparam int unsigned BINS       = 256;
  localparam int unsigned COUNT_BITS = 24;
  localparam int unsigned BAR_HEIGHT = 128;
  localparam int unsigned IDX_W      = $clog2(BINS);
  localparam int unsigned QBITS      = $clog2(BAR_HEIGHT);
  localparam int unsigned SCALE      = BAR_HEIGHT * 99;
  localparam int unsigned PCT        = 100;
  // numerator and shifted divisor both fit here
  localparam int unsigned DIV_W      = COUNT_BITS + QBITS + 7;
  localparam int unsigned CNT_W      = $clog2(QBITS + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [VAL_W-1:0]      CFG_RESET = 8'd255;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_PIX_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] ST_IDX_RANGE = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic                capture;
    logic                clear_all;
    logic                add_write;
    logic                div_load;
    logic                div_step;
    logic                load_result;
    logic                res_read;
    logic [STAT_W-1:0]   res_status;
  } dp_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             idx_ok;
    logic             peak_zero;
    logic             div_last;
    logic             out_free;
  } dp_stat_t;

  // saturating increment
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] x);
    logic [COUNT_BITS-1:0] r;
    r = (x == COUNT_MAX) ? x : x + 1'b1;
    return r;
  endfunction

endpackage

// ===== sv/phbs_ram.sv =====
module phbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/phbs_ctrl.sv =====
module phbs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  phbs_pkg::dp_stat_t stat_i,
  output phbs_pkg::dp_ctrl_t ctrl_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACT,
    S_DIV,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  // command decode and next state
  always_comb begin
    ctrl_o  = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = S_ACT;
        end
      end
      S_ACT: begin
        unique case (stat_i.cmd)
          phbs_pkg::CMD_CLEAR: begin
            if (stat_i.out_free) begin
              ctrl_o.clear_all   = 1'b1;
              ctrl_o.load_result = 1'b1;
              ctrl_o.res_status  = phbs_pkg::ST_OK;
              state_d            = S_IDLE;
            end
          end
          phbs_pkg::CMD_ADD: begin
            if (stat_i.out_free) begin
              ctrl_o.add_write   = stat_i.idx_ok;
              ctrl_o.load_result = 1'b1;
              ctrl_o.res_status  = stat_i.idx_ok ? phbs_pkg::ST_OK
                                                 : phbs_pkg::ST_PIX_RANGE;
              state_d            = S_IDLE;
            end
          end
          phbs_pkg::CMD_READ: begin
            if (!stat_i.idx_ok) begin
              if (stat_i.out_free) begin
                ctrl_o.load_result = 1'b1;
                ctrl_o.res_status  = phbs_pkg::ST_IDX_RANGE;
                state_d            = S_IDLE;
              end
            end else if (stat_i.peak_zero) begin
              if (stat_i.out_free) begin
                ctrl_o.load_result = 1'b1;
                ctrl_o.res_status  = phbs_pkg::ST_EMPTY;
                state_d            = S_IDLE;
              end
            end else begin
              ctrl_o.div_load = 1'b1;
              state_d         = S_DIV;
            end
          end
          default: begin
            // unused code: plain ok result
            if (stat_i.out_free) begin
              ctrl_o.load_result = 1'b1;
              ctrl_o.res_status  = phbs_pkg::ST_OK;
              state_d            = S_IDLE;
            end
          end
        endcase
      end
      S_DIV: begin
        ctrl_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          ctrl_o.load_result = 1'b1;
          ctrl_o.res_read    = 1'b1;
          ctrl_o.res_status  = phbs_pkg::ST_OK;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/phbs_dp.sv =====
module phbs_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  phbs_pkg::dp_ctrl_t                  ctrl_i,
  output phbs_pkg::dp_stat_t                  stat_o,
  input  logic [phbs_pkg::CMD_W-1:0]          command_i,
  input  logic [phbs_pkg::VAL_W-1:0]          value_i,
  input  logic                                cfg_we_i,
  input  logic [phbs_pkg::VAL_W-1:0]          cfg_data_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic [phbs_pkg::COUNT_BITS-1:0]     bin_count_o,
  output logic [phbs_pkg::QBITS-1:0]          bar_height_o,
  output logic [phbs_pkg::COUNT_BITS-1:0]     pixel_total_o,
  output logic [phbs_pkg::COUNT_BITS-1:0]     peak_value_o,
  output logic [phbs_pkg::STAT_W-1:0]         status_o
);

  localparam int unsigned CB = phbs_pkg::COUNT_BITS;
  localparam int unsigned DW = phbs_pkg::DIV_W;
  localparam int unsigned QB = phbs_pkg::QBITS;

  // control state
  logic [phbs_pkg::VAL_W-1:0] max_q;
  logic [phbs_pkg::BINS-1:0]  valid_q, valid_d;
  logic [CB-1:0]              total_q, total_d;
  logic [CB-1:0]              peak_q, peak_d;
  logic                       out_valid_q, out_valid_d;

  // payload
  logic [phbs_pkg::CMD_W-1:0] cmd_q;
  logic [phbs_pkg::VAL_W-1:0] val_q;
  logic                       ok_q;
  logic [DW-1:0]              num_q;
  logic [DW-1:0]              dsor_q;
  logic [QB-1:0]              quo_q;
  logic [phbs_pkg::CNT_W-1:0] cnt_q;
  logic [CB-1:0]              res_count_q;
  logic [QB-1:0]              res_bar_q;
  logic [CB-1:0]              res_total_q;
  logic [CB-1:0]              res_peak_q;
  logic [phbs_pkg::STAT_W-1:0] res_status_q;

  logic [phbs_pkg::IDX_W-1:0] idx;
  logic [CB-1:0]              ram_rdata;
  logic [CB-1:0]              cur_count;
  logic [CB-1:0]              inc_count;
  logic                       ok_d;
  logic                       div_ge;
  logic                       out_free;

  assign idx       = phbs_pkg::IDX_W'(val_q);
  assign cur_count = valid_q[idx] ? ram_rdata : '0;
  assign inc_count = phbs_pkg::sat_inc(cur_count);
  assign ok_d      = (value_i <= max_q) && (32'(value_i) < phbs_pkg::BINS);
  assign div_ge    = (num_q >= dsor_q);
  assign out_free  = !out_valid_q || !out_stall_i;

  // bin counter storage
  phbs_ram #(
    .WIDTH (CB),
    .DEPTH (phbs_pkg::BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.add_write),
    .waddr_i (idx),
    .wdata_i (inc_count),
    .re_i    (ctrl_i.capture),
    .raddr_i (phbs_pkg::IDX_W'(value_i)),
    .rdata_o (ram_rdata)
  );

  // running totals, valid bits and output handshake
  always_comb begin
    valid_d     = valid_q;
    total_d     = total_q;
    peak_d      = peak_q;
    out_valid_d = out_valid_q;
    if (ctrl_i.clear_all) begin
      valid_d = '0;
      total_d = '0;
      peak_d  = '0;
    end else if (ctrl_i.add_write) begin
      valid_d[idx] = 1'b1;
      total_d      = phbs_pkg::sat_inc(total_q);
      peak_d       = (inc_count > peak_q) ? inc_count : peak_q;
    end
    if (ctrl_i.load_result) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= phbs_pkg::CFG_RESET;
      valid_q     <= '0;
      total_q     <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_data_i;
      end
      valid_q     <= valid_d;
      total_q     <= total_d;
      peak_q      <= peak_d;
      out_valid_q <= out_valid_d;
    end
  end

  // item capture, restoring divider and result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q <= command_i;
      val_q <= value_i;
      ok_q  <= ok_d;
    end
    if (ctrl_i.div_load) begin
      num_q  <= DW'(cur_count) * DW'(phbs_pkg::SCALE);
      dsor_q <= (DW'(peak_q) * DW'(phbs_pkg::PCT)) << (QB - 1);
      quo_q  <= '0;
      cnt_q  <= phbs_pkg::CNT_W'(QB - 1);
    end else if (ctrl_i.div_step) begin
      if (div_ge) begin
        num_q <= num_q - dsor_q;
      end
      dsor_q <= dsor_q >> 1;
      quo_q  <= {quo_q[QB-2:0], div_ge};
      cnt_q  <= cnt_q - 1'b1;
    end
    if (ctrl_i.load_result) begin
      res_count_q  <= ctrl_i.res_read ? cur_count : '0;
      res_bar_q    <= ctrl_i.res_read ? quo_q : '0;
      res_total_q  <= total_d;
      res_peak_q   <= peak_d;
      res_status_q <= ctrl_i.res_status;
    end
  end

  assign stat_o.cmd       = cmd_q;
  assign stat_o.idx_ok    = ok_q;
  assign stat_o.peak_zero = (peak_q == '0);
  assign stat_o.div_last  = (cnt_q == '0);
  assign stat_o.out_free  = out_free;

  assign out_valid_o   = out_valid_q;
  assign bin_count_o   = res_count_q;
  assign bar_height_o  = res_bar_q;
  assign pixel_total_o = res_total_q;
  assign peak_value_o  = res_peak_q;
  assign status_o      = res_status_q;

endmodule

// ===== sv/pixel_histogram_bar_scaler.sv =====
// Gray-level histogram engine with one command per input transfer: clear, add pixel or
// read bin, each giving exactly one result transfer with the bin count, bar height,
// pixel total, peak count and a status code. Bin counts live in a 256 x 24 RAM with a
// registered read; per-bin valid flags make a clear take effect without rewriting the
// RAM. Clear, add and every read that ends in an error status first read the bin, then
// load the result; an add also writes the incremented count back. A read of an in-range
// bin with a nonzero peak goes on to the bar-height divider, one quotient bit per cycle
// after the multiply. The result register lets the next command be taken while the last
// result still waits to be transferred. The user must write max_pixel_value through the
// config port only while the block is idle; the block itself does not enforce this.
`include "pixel_histogram_bar_scaler_assert.svh"

module pixel_histogram_bar_scaler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [phbs_pkg::CMD_W-1:0]      command_i,
  input  logic [phbs_pkg::VAL_W-1:0]      value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [phbs_pkg::COUNT_BITS-1:0] bin_count_o,
  output logic [phbs_pkg::QBITS-1:0]      bar_height_o,
  output logic [phbs_pkg::COUNT_BITS-1:0] pixel_total_o,
  output logic [phbs_pkg::COUNT_BITS-1:0] peak_value_o,
  output logic [phbs_pkg::STAT_W-1:0]     status_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [phbs_pkg::VAL_W-1:0]      cfg_data_i
);

  phbs_pkg::dp_ctrl_t ctrl;
  phbs_pkg::dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  // sequencer
  phbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // bins, totals, divider and result register
  phbs_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .command_i     (command_i),
    .value_i       (value_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .bin_count_o   (bin_count_o),
    .bar_height_o  (bar_height_o),
    .pixel_total_o (pixel_total_o),
    .peak_value_o  (peak_value_o),
    .status_o      (status_o)
  );

  // one command in flight at a time
  `PHBS_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // error results carry no count or bar
  `PHBS_ASSERT_NOW(a_err_zero, clk_i, rst_ni, out_valid_o && (status_o != phbs_pkg::ST_OK),
                   (bin_count_o == '0) && (bar_height_o == '0))

  // no bin ever exceeds the peak
  `PHBS_ASSERT_NOW(a_peak_bound, clk_i, rst_ni, out_valid_o, bin_count_o <= peak_value_o)

endmodule
